/* rtl/laplacian_edge_filter_3x3_top_defines.svh */
// assertion macros for the laplacian edge filter checker
// needs a clk and a rst signal in the scope that uses them
`ifndef LAPLACIAN_EDGE_FILTER_3X3_TOP_DEFINES_SVH
`define LAPLACIAN_EDGE_FILTER_3X3_TOP_DEFINES_SVH

// checked only outside reset
`define LEF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LEF_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lef_pkg.sv */
// shared constants for the laplacian edge filter
// no dependencies
`default_nettype none

package lef_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int OUT_X_W    = 11;
  localparam int OUT_Y_W    = 12;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CHCOUNT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MIN_DIM    = 3;
  localparam int PIX_MAX    = 255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  // register reset values
  localparam logic [WIDTH_W-1:0]   RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [HEIGHT_W-1:0]  RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [CHCOUNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;

  typedef logic [CH_W-1:0] pix_t;

endpackage

`default_nettype wire

/* rtl/lef_if.sv */
// valid/ready channel interfaces: pixel input, filter result, register write
// depends on lef_pkg
`default_nettype none

interface lef_pix_if;
  logic             valid;
  logic             ready;
  logic             start_of_frame;
  lef_pkg::pix_t    in_ch0;
  lef_pkg::pix_t    in_ch1;
  lef_pkg::pix_t    in_ch2;
  lef_pkg::pix_t    in_ch3;

  modport source (output valid, start_of_frame, in_ch0, in_ch1, in_ch2, in_ch3,
                  input ready);
  modport sink (input valid, start_of_frame, in_ch0, in_ch1, in_ch2, in_ch3,
                output ready);
endinterface

interface lef_res_if;
  logic                        valid;
  logic                        ready;
  logic [lef_pkg::OUT_X_W-1:0] out_x;
  logic [lef_pkg::OUT_Y_W-1:0] out_y;
  lef_pkg::pix_t               out_ch0;
  lef_pkg::pix_t               out_ch1;
  lef_pkg::pix_t               out_ch2;
  lef_pkg::pix_t               out_ch3;
  logic                        last_of_frame;

  modport source (output valid, out_x, out_y, out_ch0, out_ch1, out_ch2, out_ch3,
                  last_of_frame, input ready);
  modport sink (input valid, out_x, out_y, out_ch0, out_ch1, out_ch2, out_ch3,
                last_of_frame, output ready);
endinterface

interface lef_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lef_pkg::CFG_IDX_W-1:0]  index;
  logic [lef_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/lef_line_store.sv */
// one line store: single write port, single registered read port
// no dependencies
`default_nettype none

module lef_line_store #(
  parameter int DEPTH = 2048,
  parameter int DW    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [DW-1:0]            rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/lef_lane.sv */
// one channel lane: 8 x centre minus the eight neighbours, clamped to 0..255
// depends on lef_pkg
`default_nettype none

module lef_lane (
  input  wire logic [lef_pkg::CH_W-1:0]       centre,
  input  wire logic [7:0][lef_pkg::CH_W-1:0]  nbr,
  output      lef_pkg::pix_t                  lap
);

  localparam int SW = lef_pkg::CH_W + 3;   // sum of eight samples
  localparam int DW = SW + 1;              // signed difference

  logic [SW-1:0]        nbr_sum;
  logic [SW-1:0]        centre_x8;
  logic signed [DW-1:0] diff;

  always_comb begin
    nbr_sum = '0;
    for (int i = 0; i < 8; i++) begin
      nbr_sum = nbr_sum + SW'(nbr[i]);
    end
  end

  assign centre_x8 = {centre, 3'b000};
  assign diff      = $signed({1'b0, centre_x8}) - $signed({1'b0, nbr_sum});

  always_comb begin
    if (diff < 0) begin
      lap = '0;
    end else if (diff > DW'(lef_pkg::PIX_MAX)) begin
      lap = lef_pkg::CH_W'(lef_pkg::PIX_MAX);
    end else begin
      lap = diff[lef_pkg::CH_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/laplacian_edge_filter_3x3_top.sv */
// top level of the 3x3 laplacian edge filter
// depends on lef_pkg, lef_if, lef_line_store and lef_lane
`default_nettype none

// Streams raster-order pixels of up to four 8-bit channels and returns, for
// every interior pixel, 8 x centre minus its eight neighbours per channel,
// clamped to 0..255; border pixels give no result. The block takes one pixel
// per clock with no bubbles while the output is not stalled: a pixel is
// accepted in stage 0, where the two line stores (MAX_WIDTH words each) are
// read at its column; in stage 1 the LANES lanes evaluate the 3x3 window in
// parallel and the line stores and window registers are updated; the merged
// result loads into the output register from the stage 1 registers as stage
// 1 advances. While a result waits in the output register, pixels are still
// taken until one that yields a result is held in stage 1. Channels at or
// beyond channel_count, and
// lanes at or beyond LANES, give zero. start_of_frame restarts the position
// counters; otherwise they wrap at the end of each frame. Width and height
// outside 3..MAX_WIDTH / 3..MAX_HEIGHT are clamped, channel_count to
// 1..LANES. Line stores have no reset and need no clearing pass; registers
// should be written only while the block is idle.
module laplacian_edge_filter_3x3_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int LANES      = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  lef_pix_if.sink   pixels,
  lef_res_if.source results,
  lef_cfg_if.sink   cfg
);

  localparam int CH_W = lef_pkg::CH_W;
  localparam int XW   = $clog2(MAX_WIDTH);       // column counter
  localparam int XLW  = XW + 1;                  // width limit
  localparam int YW   = $clog2(MAX_HEIGHT);      // row counter
  localparam int YLW  = YW + 1;                  // height limit
  localparam int WCW  = (XLW > lef_pkg::WIDTH_W) ? XLW : lef_pkg::WIDTH_W;
  localparam int HCW  = (YLW > lef_pkg::HEIGHT_W) ? YLW : lef_pkg::HEIGHT_W;
  localparam int XEW  = (XW > lef_pkg::OUT_X_W) ? XW : lef_pkg::OUT_X_W;
  localparam int YEW  = (YW > lef_pkg::OUT_Y_W) ? YW : lef_pkg::OUT_Y_W;
  localparam int PW   = LANES * CH_W;            // packed pixel word

  // configuration registers
  logic [lef_pkg::WIDTH_W-1:0]   image_width;
  logic [lef_pkg::HEIGHT_W-1:0]  image_height;
  logic [lef_pkg::CHCOUNT_W-1:0] channel_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= lef_pkg::RST_IMAGE_WIDTH;
      image_height  <= lef_pkg::RST_IMAGE_HEIGHT;
      channel_count <= lef_pkg::RST_CHANNEL_COUNT;
    end else if (cfg.valid) begin
      case (cfg.index)
        lef_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg.data[lef_pkg::WIDTH_W-1:0];
        end
        lef_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg.data[lef_pkg::HEIGHT_W-1:0];
        end
        lef_pkg::REG_CHANNEL_COUNT: begin
          channel_count <= cfg.data[lef_pkg::CHCOUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective frame size and channel count
  logic [WCW-1:0]                w_raw;
  logic [HCW-1:0]                h_raw;
  logic [XLW-1:0]                w_lim;
  logic [YLW-1:0]                h_lim;
  logic [lef_pkg::CHCOUNT_W-1:0] nch;

  assign w_raw = WCW'(image_width);
  assign h_raw = HCW'(image_height);

  always_comb begin
    if (w_raw < WCW'(lef_pkg::MIN_DIM)) begin
      w_lim = XLW'(lef_pkg::MIN_DIM);
    end else if (w_raw > WCW'(MAX_WIDTH)) begin
      w_lim = XLW'(MAX_WIDTH);
    end else begin
      w_lim = w_raw[XLW-1:0];
    end
    if (h_raw < HCW'(lef_pkg::MIN_DIM)) begin
      h_lim = YLW'(lef_pkg::MIN_DIM);
    end else if (h_raw > HCW'(MAX_HEIGHT)) begin
      h_lim = YLW'(MAX_HEIGHT);
    end else begin
      h_lim = h_raw[YLW-1:0];
    end
    if (channel_count == '0) begin
      nch = lef_pkg::CHCOUNT_W'(1);
    end else if (channel_count > lef_pkg::CHCOUNT_W'(LANES)) begin
      nch = lef_pkg::CHCOUNT_W'(LANES);
    end else begin
      nch = channel_count;
    end
  end

  // handshake control
  logic accept;
  logic out_can;
  logic s1_valid;
  logic s1_has_res;
  logic s1_adv;
  logic res_valid;

  assign out_can      = !res_valid || results.ready;
  assign s1_adv       = s1_valid && (!s1_has_res || out_can);
  assign pixels.ready = !s1_valid || s1_adv;
  assign accept       = pixels.valid && pixels.ready;

  // stage 0: position of the incoming pixel
  logic [XW-1:0]  col_cnt;
  logic [YW-1:0]  row_cnt;
  logic [XW-1:0]  col_base;
  logic [YW-1:0]  row_base;
  logic [XW-1:0]  col_cur;
  logic [YW-1:0]  row_cur;
  logic [XLW-1:0] col_inc;
  logic [YLW-1:0] row_inc;
  logic [XW-1:0]  col_cnt_next;
  logic [YW-1:0]  row_cnt_next;
  logic           has_res0;
  logic           last0;

  always_comb begin
    col_base = pixels.start_of_frame ? '0 : col_cnt;
    row_base = pixels.start_of_frame ? '0 : row_cnt;
    // counters past a shrunken frame restart at zero
    col_cur  = ({1'b0, col_base} >= w_lim) ? '0 : col_base;
    row_cur  = ({1'b0, row_base} >= h_lim) ? '0 : row_base;
    col_inc  = {1'b0, col_cur} + XLW'(1);
    row_inc  = {1'b0, row_cur} + YLW'(1);
    if (col_inc >= w_lim) begin
      col_cnt_next = '0;
      row_cnt_next = (row_inc >= h_lim) ? '0 : row_inc[YW-1:0];
    end else begin
      col_cnt_next = col_inc[XW-1:0];
      row_cnt_next = row_cur;
    end
    has_res0 = (col_cur >= XW'(2)) && (row_cur >= YW'(2));
    last0    = ({1'b0, col_cur} == w_lim - XLW'(1)) &&
               ({1'b0, row_cur} == h_lim - YLW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // incoming pixel packed per lane, inactive channels zeroed
  lef_pkg::pix_t [lef_pkg::NUM_CH-1:0] in_bytes;
  logic [PW-1:0]                       cur_word;

  assign in_bytes = {pixels.in_ch3, pixels.in_ch2, pixels.in_ch1, pixels.in_ch0};

  for (genvar k = 0; k < LANES; k++) begin : g_pack
    assign cur_word[k*CH_W +: CH_W] =
      (lef_pkg::CHCOUNT_W'(k) < nch) ? in_bytes[k] : '0;
  end

  // stage 1 registers
  logic [XW-1:0] s1_col;
  logic [YW-1:0] s1_row;
  logic          s1_last;
  logic [PW-1:0] s1_cur;
  logic          s1_fwd;
  logic [PW-1:0] s1_fwd_top;
  logic [PW-1:0] s1_fwd_mid;
  logic [PW-1:0] top_rd;
  logic [PW-1:0] mid_rd;
  logic [PW-1:0] s1_top;
  logic [PW-1:0] s1_mid;

  // the stored words come from line store reads, unless the pixel leaving
  // stage 1 in the same cycle wrote the same column (back-to-back frame starts)
  assign s1_top = s1_fwd ? s1_fwd_top : top_rd;
  assign s1_mid = s1_fwd ? s1_fwd_mid : mid_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= col_cur;
      s1_row     <= row_cur;
      s1_has_res <= has_res0;
      s1_last    <= last0;
      s1_cur     <= cur_word;
      s1_fwd     <= s1_adv && (s1_col == col_cur);
      s1_fwd_top <= s1_mid;
      s1_fwd_mid <= s1_cur;
    end
  end

  // line stores: top holds the row two up, mid the row just above
  lef_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (PW)
  ) u_top_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (top_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (s1_mid)
  );

  lef_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (PW)
  ) u_mid_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (mid_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (s1_cur)
  );

  // window: entries 0..2 two columns back, 3..5 one column back
  // (top, mid, bottom row in each group)
  logic [PW-1:0] win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= s1_top;
      win[4] <= s1_mid;
      win[5] <= s1_cur;
    end
  end

  // parallel lanes, then merge into the four output channels
  lef_pkg::pix_t [lef_pkg::NUM_CH-1:0] lane_res;

  for (genvar k = 0; k < lef_pkg::NUM_CH; k++) begin : g_lane
    if (k < LANES) begin : g_on
      logic [7:0][CH_W-1:0] nbr;
      assign nbr = {win[0][k*CH_W +: CH_W], win[1][k*CH_W +: CH_W],
                    win[2][k*CH_W +: CH_W], win[3][k*CH_W +: CH_W],
                    win[5][k*CH_W +: CH_W], s1_top[k*CH_W +: CH_W],
                    s1_mid[k*CH_W +: CH_W], s1_cur[k*CH_W +: CH_W]};
      lef_lane u_lane (
        .centre (win[4][k*CH_W +: CH_W]),
        .nbr    (nbr),
        .lap    (lane_res[k])
      );
    end else begin : g_off
      assign lane_res[k] = '0;
    end
  end

  // result coordinates: one column left and one row above the newest pixel
  logic [XEW-1:0] x_ext;
  logic [YEW-1:0] y_ext;

  assign x_ext = XEW'(s1_col) - XEW'(1);
  assign y_ext = YEW'(s1_row) - YEW'(1);

  // output register
  logic                                res_load;
  logic [lef_pkg::OUT_X_W-1:0]         res_x;
  logic [lef_pkg::OUT_Y_W-1:0]         res_y;
  lef_pkg::pix_t [lef_pkg::NUM_CH-1:0] res_ch;
  logic                                res_last;

  assign res_load = s1_adv && s1_has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_x    <= x_ext[lef_pkg::OUT_X_W-1:0];
      res_y    <= y_ext[lef_pkg::OUT_Y_W-1:0];
      res_ch   <= lane_res;
      res_last <= s1_last;
    end
  end

  assign results.valid         = res_valid;
  assign results.out_x         = res_x;
  assign results.out_y         = res_y;
  assign results.out_ch0       = res_ch[0];
  assign results.out_ch1       = res_ch[1];
  assign results.out_ch2       = res_ch[2];
  assign results.out_ch3       = res_ch[3];
  assign results.last_of_frame = res_last;

endmodule

`default_nettype wire

/* rtl/lef_checker.sv */
// port-level checks for laplacian_edge_filter_3x3_top, attached by bind
// depends on lef_pkg and laplacian_edge_filter_3x3_top_defines.svh
`default_nettype none

`include "laplacian_edge_filter_3x3_top_defines.svh"

module lef_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        pix_ready,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic [lef_pkg::OUT_X_W-1:0] res_x,
  input wire logic [lef_pkg::OUT_Y_W-1:0] res_y,
  input wire lef_pkg::pix_t               res_ch0,
  input wire lef_pkg::pix_t               res_ch3,
  input wire logic                        res_last,
  input wire logic                        cfg_ready
);

  // a stalled result keeps its payload
  `LEF_ASSERT_RST(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_y) && $stable(res_ch0) && $stable(res_ch3) && $stable(res_last), "result changed while stalled")

  // only interior pixels produce a result
  `LEF_ASSERT_RST(a_interior, res_valid |-> res_x != '0 && res_y != '0, "border pixel produced a result")

  // with the output register empty, nothing can block the input
  `LEF_ASSERT_RST(a_ready_empty, !res_valid |-> pix_ready, "input blocked with empty output")

  // register writes are never stalled
  `LEF_ASSERT_RST(a_cfg_ready, cfg_ready, "config port not ready")

  // reset empties the output register
  `LEF_ASSERT_ANY(a_reset_empty, $past(rst) |-> !res_valid, "result valid right after reset")

endmodule

bind laplacian_edge_filter_3x3_top lef_checker u_lef_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pixels.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_x     (results.out_x),
  .res_y     (results.out_y),
  .res_ch0   (results.out_ch0),
  .res_ch3   (results.out_ch3),
  .res_last  (results.last_of_frame),
  .cfg_ready (cfg.ready)
);

`default_nettype wire

/* tb/laplacian_edge_filter_3x3_top_tb.sv */
// self-checking testbench for the 3x3 laplacian edge filter top level
// depends on lef_pkg, the lef_if interfaces and laplacian_edge_filter_3x3_top
`default_nettype none

module laplacian_edge_filter_3x3_top_tb;

  localparam int MAX_W  = 2048;
  localparam int MAX_H  = 4096;
  localparam int LANES  = 4;
  // cycles allowed after the last transaction before the block counts as idle
  localparam int SETTLE = 8;
  localparam int LIMIT  = 100_000;

  // unmapped register index, writes to it must change nothing
  localparam logic [lef_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic          sof;
    lef_pkg::pix_t ch [lef_pkg::NUM_CH];
  } pixel_t;

  typedef struct {
    logic [lef_pkg::OUT_X_W-1:0] x;
    logic [lef_pkg::OUT_Y_W-1:0] y;
    lef_pkg::pix_t               ch [lef_pkg::NUM_CH];
    logic                        frame_end;
  } lap_result_t;

  typedef struct {
    logic [lef_pkg::CFG_IDX_W-1:0]  idx;
    logic [lef_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  lef_pix_if pix_bus ();
  lef_res_if res_bus ();
  lef_cfg_if cfg_bus ();

  laplacian_edge_filter_3x3_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .LANES     (LANES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_bus),
    .results(res_bus),
    .cfg    (cfg_bus)
  );

  // pending pixels, expected filter results and pending register writes
  pixel_t      pixel_q [$];
  lap_result_t expected_q [$];
  reg_write_t  cfg_pending [$];

  // predictor state: register mirror, line stores, window, raster position
  logic [lef_pkg::WIDTH_W-1:0]   width_reg;
  logic [lef_pkg::HEIGHT_W-1:0]  height_reg;
  logic [lef_pkg::CHCOUNT_W-1:0] chans_reg;
  bit [31:0]            mid_line [MAX_W];
  bit [31:0]            top_line [MAX_W];
  bit [31:0]            window [6];
  // how often each column has passed through the line stores, saturating at 2
  bit [1:0]             col_visits [MAX_W];
  int unsigned          col_pos;
  int unsigned          row_pos;

  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned pixels_pushed;
  int unsigned pixels_taken;
  int unsigned results_checked;
  int unsigned cfg_writes;
  int unsigned err_count;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamped register values as the datapath sees them
  function automatic int unsigned eff_width();
    if (width_reg < lef_pkg::MIN_DIM) return lef_pkg::MIN_DIM;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < lef_pkg::MIN_DIM) return lef_pkg::MIN_DIM;
    if (height_reg > MAX_H) return MAX_H;
    return height_reg;
  endfunction

  function automatic int unsigned eff_channels();
    if (chans_reg == 0) return 1;
    if (chans_reg > LANES) return LANES;
    return chans_reg;
  endfunction

  // advance the predictor by one accepted pixel, queue the result it yields
  function automatic void filter_pixel(input logic sof,
                                       input lef_pkg::pix_t s0, input lef_pkg::pix_t s1,
                                       input lef_pkg::pix_t s2, input lef_pkg::pix_t s3);
    int unsigned   w, h, n, k, j;
    logic [31:0]   cur, top, mid;
    lef_pkg::pix_t smp [lef_pkg::NUM_CH];
    int            acc;
    lap_result_t   r;
    w = eff_width();
    h = eff_height();
    n = eff_channels();
    smp = '{s0, s1, s2, s3};
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a shrunken frame restarts the counters
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    cur = '0;
    for (k = 0; k < n; k++) cur[8*k +: 8] = smp[k];
    top = top_line[col_pos];
    mid = mid_line[col_pos];
    if (col_pos >= 2 && row_pos >= 2) begin
      for (k = 0; k < lef_pkg::NUM_CH; k++) begin
        acc = 8 * int'(window[4][8*k +: 8]) - int'(top[8*k +: 8])
              - int'(mid[8*k +: 8]) - int'(cur[8*k +: 8]);
        for (j = 0; j < 6; j++)
          if (j != 4) acc -= int'(window[j][8*k +: 8]);
        if (acc < 0) acc = 0;
        if (acc > lef_pkg::PIX_MAX) acc = lef_pkg::PIX_MAX;
        r.ch[k] = lef_pkg::pix_t'(acc);
      end
      r.x = lef_pkg::OUT_X_W'(col_pos - 1);
      r.y = lef_pkg::OUT_Y_W'(row_pos - 1);
      r.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
      expected_q.insert(expected_q.size(), r);
    end
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = top;
    window[4] = mid;
    window[5] = cur;
    top_line[col_pos] = mid;
    mid_line[col_pos] = cur;
    if (col_visits[col_pos] < 2) col_visits[col_pos]++;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // pixel driver: predicts at each accepted transaction, then offers the next pixel
  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    if (rst) begin
      pix_bus.valid <= 1'b0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        filter_pixel(pix_bus.start_of_frame, pix_bus.in_ch0, pix_bus.in_ch1,
                     pix_bus.in_ch2, pix_bus.in_ch3);
        pixels_taken++;
      end
      if (!pix_bus.valid || pix_bus.ready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= src_gap_pct) begin
          nxt = pixel_q.pop_front();
          pix_bus.valid          <= 1'b1;
          pix_bus.start_of_frame <= nxt.sof;
          pix_bus.in_ch0         <= nxt.ch[0];
          pix_bus.in_ch1         <= nxt.ch[1];
          pix_bus.in_ch2         <= nxt.ch[2];
          pix_bus.in_ch3         <= nxt.ch[3];
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: every result transaction against the oldest expectation
  always @(posedge clk) begin : result_monitor
    lap_result_t   want;
    lef_pkg::pix_t got_ch [lef_pkg::NUM_CH];
    int unsigned   k;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got_ch = '{res_bus.out_ch0, res_bus.out_ch1, res_bus.out_ch2, res_bus.out_ch3};
        if (expected_q.size() == 0) begin
          $error("unexpected result at out_x %0d, out_y %0d", res_bus.out_x, res_bus.out_y);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          check_field("out_x", want.x, res_bus.out_x);
          check_field("out_y", want.y, res_bus.out_y);
          for (k = 0; k < lef_pkg::NUM_CH; k++)
            check_field($sformatf("out_ch%0d", k), want.ch[k], got_ch[k]);
          check_field("last_of_frame", want.frame_end, res_bus.last_of_frame);
        end
      end
      res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // hard stop in case the block hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic lef_pkg::pix_t rand_sample();
    case ($urandom_range(3))
      0:       return '0;
      1:       return lef_pkg::pix_t'(lef_pkg::PIX_MAX);
      default: return lef_pkg::pix_t'($urandom_range(lef_pkg::PIX_MAX));
    endcase
  endfunction

  task automatic push_exact(input logic sof, input lef_pkg::pix_t c0, input lef_pkg::pix_t c1,
                            input lef_pkg::pix_t c2, input lef_pkg::pix_t c3);
    pixel_t p;
    p.sof = sof;
    p.ch  = '{c0, c1, c2, c3};
    pixel_q.insert(pixel_q.size(), p);
    pixels_pushed++;
  endtask

  task automatic push_pixel(input logic sof);
    push_exact(sof, rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  task automatic queue_write(input logic [lef_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lef_pkg::CFG_DATA_W-1:0] data);
    reg_write_t wr;
    wr.idx  = idx;
    wr.data = data;
    cfg_pending.insert(cfg_pending.size(), wr);
  endtask

  // back-to-back register writes, valid held high across them
  task automatic apply_config();
    reg_write_t wr;
    while (cfg_pending.size() > 0) begin
      wr = cfg_pending.pop_front();
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= wr.idx;
      cfg_bus.data  <= wr.data;
      do @(posedge clk); while (!cfg_bus.ready);
      cfg_writes++;
      case (wr.idx)
        lef_pkg::REG_IMAGE_WIDTH:   width_reg  = wr.data[lef_pkg::WIDTH_W-1:0];
        lef_pkg::REG_IMAGE_HEIGHT:  height_reg = wr.data[lef_pkg::HEIGHT_W-1:0];
        lef_pkg::REG_CHANNEL_COUNT: chans_reg  = wr.data[lef_pkg::CHCOUNT_W-1:0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // sender holds back until every pixel is in and every result is out
  task automatic drain();
    while (pixels_taken != pixels_pushed || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // a column read before it was stored twice would hit an unwritten line entry,
  // so such a width must begin with a fresh frame
  function automatic bit must_restart();
    int unsigned c, w;
    w = eff_width();
    for (c = 0; c < w; c++)
      if (col_visits[c] < 2) return 1'b1;
    return 1'b0;
  endfunction

  // one 3x3 frame: a centre pixel in a uniform border
  task automatic frame3x3(input logic sof, input lef_pkg::pix_t cen [lef_pkg::NUM_CH],
                          input lef_pkg::pix_t bdr [lef_pkg::NUM_CH]);
    int unsigned i;
    for (i = 0; i < 9; i++) begin
      if (i == 4) push_exact(1'b0, cen[0], cen[1], cen[2], cen[3]);
      else push_exact(sof && i == 0, bdr[0], bdr[1], bdr[2], bdr[3]);
    end
  endtask

  // well-formed frames of random content, small geometry, aliased sizes now and then
  task automatic frames_segment();
    int unsigned wv, hv, frames, n, f, i;
    bit wide;
    wide = ($urandom_range(9) == 0);
    wv = ($urandom_range(7) == 0) ? $urandom_range(2) :
         wide ? $urandom_range(13, 40) : $urandom_range(3, 12);
    hv = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 7);
    queue_write(lef_pkg::REG_IMAGE_WIDTH, {1'($urandom_range(1)), 12'(wv)});
    queue_write(lef_pkg::REG_IMAGE_HEIGHT, 13'(hv));
    if ($urandom_range(1))
      queue_write(lef_pkg::REG_CHANNEL_COUNT, {10'($urandom), 3'($urandom_range(7))});
    apply_config();
    frames = wide ? 1 : $urandom_range(1, 3);
    n = eff_width() * eff_height();
    // later frames either restart or just roll over from the end of the last one
    for (f = 0; f < frames; f++)
      for (i = 0; i < n; i++)
        push_pixel(i == 0 && (f == 0 || $urandom_range(1)));
  endtask

  // resize in the middle of a frame, mostly shrinking below the current position
  task automatic resize_segment();
    int unsigned cap, n, i;
    bit restart;
    cap = (eff_width() < 40) ? eff_width() : 40;
    case ($urandom_range(2))
      0: queue_write(lef_pkg::REG_IMAGE_WIDTH, 13'($urandom_range(3, cap)));
      1: queue_write(lef_pkg::REG_IMAGE_HEIGHT, 13'($urandom_range(3, 8)));
      default: begin
        queue_write(lef_pkg::REG_IMAGE_WIDTH, 13'($urandom_range(3, 40)));
        queue_write(lef_pkg::REG_IMAGE_HEIGHT, 13'($urandom_range(3, 8)));
      end
    endcase
    if ($urandom_range(3) == 0) queue_write(REG_SPARE, 13'($urandom));
    if ($urandom_range(3) == 0)
      queue_write(lef_pkg::REG_CHANNEL_COUNT, {10'($urandom), 3'($urandom_range(7))});
    apply_config();
    restart = must_restart();
    n = $urandom_range(10, 60);
    for (i = 0; i < n; i++) push_pixel(i == 0 && restart);
  endtask

  // same geometry, start_of_frame dropped in at random spots
  task automatic noise_segment();
    int unsigned n, i;
    bit restart;
    restart = must_restart();
    n = $urandom_range(20, 80);
    for (i = 0; i < n; i++) push_pixel((i == 0 && restart) || $urandom_range(24) == 0);
  endtask

  initial begin : stimulus
    int unsigned phase, budget, pick, i;
    lef_pkg::pix_t cen [lef_pkg::NUM_CH];
    lef_pkg::pix_t bdr [lef_pkg::NUM_CH];

    // known values on every input from time zero
    rst                    = 1'b1;
    pix_bus.valid          = 1'b0;
    pix_bus.start_of_frame = 1'b0;
    pix_bus.in_ch0         = '0;
    pix_bus.in_ch1         = '0;
    pix_bus.in_ch2         = '0;
    pix_bus.in_ch3         = '0;
    res_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
    width_reg      = lef_pkg::RST_IMAGE_WIDTH;
    height_reg     = lef_pkg::RST_IMAGE_HEIGHT;
    chans_reg      = lef_pkg::RST_CHANNEL_COUNT;
    col_pos        = 0;
    row_pos        = 0;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    pixels_pushed  = 0;
    pixels_taken   = 0;
    results_checked = 0;
    cfg_writes     = 0;
    err_count      = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sizes below the minimum act as 3, channel count above 4 acts as 4,
    // an ignored upper data bit on the width write
    queue_write(lef_pkg::REG_IMAGE_WIDTH, {1'b1, 12'd2});
    queue_write(lef_pkg::REG_IMAGE_HEIGHT, 13'd0);
    queue_write(lef_pkg::REG_CHANNEL_COUNT, 13'd7);
    apply_config();
    // bright centre on black: clamps high on three lanes, small value on the fourth
    cen = '{8'hFF, 8'hAA, 8'h55, 8'h01};
    bdr = '{8'h00, 8'h00, 8'h00, 8'h00};
    frame3x3(1'b1, cen, bdr);
    // dark centre on white, frame starts by wrap-around with no start_of_frame
    cen = '{8'h00, 8'h00, 8'h00, 8'h00};
    bdr = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    frame3x3(1'b0, cen, bdr);
    drain();
    // channel count 0 acts as one channel, upper lanes must read zero
    queue_write(lef_pkg::REG_CHANNEL_COUNT, 13'h1FF8);
    apply_config();
    cen = '{8'h10, 8'hFF, 8'hFF, 8'hFF};
    bdr = '{8'h0F, 8'hF0, 8'hFF, 8'hFF};
    frame3x3(1'b1, cen, bdr);

    // random part: receiver-heavy idling, sender-heavy idling, then none
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_gap_pct = 7;  sink_stall_pct = 61; end
        1:       begin src_gap_pct = 61; sink_stall_pct = 7;  end
        default: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
      endcase
      budget = pixels_pushed + 450;
      while (pixels_pushed < budget) begin
        // each segment waits for the pipe to empty, which also gives full backpressure
        // relief before any register write
        drain();
        pick = $urandom_range(9);
        if (pick < 6) frames_segment();
        else if (pick < 8) resize_segment();
        else noise_segment();
      end
    end

    // tall narrow frame: height field all ones clamps to the maximum, partial frame
    drain();
    queue_write(lef_pkg::REG_IMAGE_WIDTH, 13'd0);
    queue_write(lef_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    queue_write(lef_pkg::REG_CHANNEL_COUNT, 13'd4);
    apply_config();
    for (i = 0; i < 150; i++) push_pixel(i == 0);

    drain();
    $display("streamed %0d pixels through %0d register writes, %0d filtered pixels compared",
             pixels_taken, cfg_writes, results_checked);
    $display("geometry ranged from clamped 3x3 frames to 40-pixel rows and a clamped tall frame");
    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

/* laplacian_edge_filter_3x3_top.f */
+incdir+rtl
rtl/lef_pkg.sv
rtl/lef_if.sv
rtl/lef_line_store.sv
rtl/lef_lane.sv
rtl/laplacian_edge_filter_3x3_top.sv
rtl/lef_checker.sv
tb/laplacian_edge_filter_3x3_top_tb.sv
